// ----- hw/rtl/pma_pkg.sv -----
// Shared types, widths and constants of the pointer motion accelerator.
package pma_pkg;

   // Field widths
   localparam int SENS_W       = 9;
   localparam int DIM_W        = 14;
   localparam int HOT_W        = 8;
   localparam int RAW_W        = 16;
   localparam int MAG_W        = 17;
   localparam int GAIN_W       = 8;
   localparam int FACTOR_W     = 10;
   localparam int MOVE_MAG_W   = 19;
   localparam int MOVE_W       = 20;
   localparam int HOT_SCALED_W = 9;
   localparam int POS_OUT_W    = 13;
   localparam int DRAW_W       = 14;
   localparam int BTN_W        = 8;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 14;

   // Shared multiplier
   localparam int MUL_W       = 26;
   localparam int BIAS_W      = 7;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int RECIP_SHIFT = 32;
   // ceil(2^32 / 100): exact floor quotient for dividends below 2^30
   localparam logic [MUL_W-1:0] RECIP_100 = 26'd42949673;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SENS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_Y  = 3'd4;

   // Register limits and reset values
   localparam logic [SENS_W-1:0] SENS_MIN     = 9'd10;
   localparam logic [SENS_W-1:0] SENS_MAX     = 9'd400;
   localparam logic [SENS_W-1:0] SENS_RESET   = 9'd100;
   localparam logic [DIM_W-1:0]  WIDTH_RESET  = 14'd1920;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET = 14'd1080;

   // Acceleration thresholds and gains (percent)
   localparam logic [MAG_W-1:0]  THR_HIGH   = 17'd24;
   localparam logic [MAG_W-1:0]  THR_MID    = 17'd12;
   localparam logic [MAG_W-1:0]  THR_LOW    = 17'd6;
   localparam logic [GAIN_W-1:0] GAIN_HIGH  = 8'd220;
   localparam logic [GAIN_W-1:0] GAIN_MID   = 8'd170;
   localparam logic [GAIN_W-1:0] GAIN_LOW   = 8'd130;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 8'd100;
   localparam logic [GAIN_W-1:0] HOT_SCALE  = 8'd150;
   localparam logic [BIAS_W-1:0] ROUND_BIAS = 7'd50;

   typedef struct packed {
      logic [SENS_W-1:0] sens;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [HOT_W-1:0]  hot_x;
      logic [HOT_W-1:0]  hot_y;
   } cfg_type;

   typedef struct packed {
      logic [MUL_W-1:0]  a;
      logic [MUL_W-1:0]  b;
      logic [BIAS_W-1:0] c;
   } mac_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_X_GAIN,
      ST_X_FDIV,
      ST_X_MAG,
      ST_X_SDIV,
      ST_Y_GAIN,
      ST_Y_FDIV,
      ST_Y_MAG,
      ST_Y_SDIV,
      ST_HX_MUL,
      ST_HX_DIV,
      ST_HY_MUL,
      ST_HY_DIV,
      ST_HOT_CAP,
      ST_UPDATE
   } state_type;

endpackage

// ----- hw/rtl/pma_mac.sv -----
// Shared multiply-add unit with registered product.
module pma_mac (
   input  logic                                  clock,
   input  pma_pkg::mac_op_type                   op,
   output logic [pma_pkg::PROD_W-1:0]            prod
);

   logic [pma_pkg::PROD_W-1:0] prod_ff;
   logic [pma_pkg::PROD_W-1:0] prod_in;

   // a * b + c
   assign prod_in = pma_pkg::PROD_W'(op.a) * pma_pkg::PROD_W'(op.b)
                    + pma_pkg::PROD_W'(op.c);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/pma_csr.sv -----
// Configuration registers with sensitivity saturation.
module pma_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pma_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pma_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output pma_pkg::cfg_type                   cfg
);

   pma_pkg::cfg_type           cfg_ff;
   pma_pkg::cfg_type           cfg_in;
   logic [pma_pkg::SENS_W-1:0] sens_raw;
   logic [pma_pkg::SENS_W-1:0] sens_sat;

   // writes are taken whenever the block is out of reset
   assign csr_ready = !reset;

   // Sensitivity saturates into its legal range
   always_comb begin
      sens_raw = csr_wdata[pma_pkg::SENS_W-1:0];
      if (sens_raw < pma_pkg::SENS_MIN) begin
         sens_sat = pma_pkg::SENS_MIN;
      end else if (sens_raw > pma_pkg::SENS_MAX) begin
         sens_sat = pma_pkg::SENS_MAX;
      end else begin
         sens_sat = sens_raw;
      end
   end

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pma_pkg::CSR_SENS:   cfg_in.sens   = sens_sat;
            pma_pkg::CSR_WIDTH:  cfg_in.width  = csr_wdata;
            pma_pkg::CSR_HEIGHT: cfg_in.height = csr_wdata;
            pma_pkg::CSR_HOT_X:  cfg_in.hot_x  = csr_wdata[pma_pkg::HOT_W-1:0];
            pma_pkg::CSR_HOT_Y:  cfg_in.hot_y  = csr_wdata[pma_pkg::HOT_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sens   <= pma_pkg::SENS_RESET;
         cfg_ff.width  <= pma_pkg::WIDTH_RESET;
         cfg_ff.height <= pma_pkg::HEIGHT_RESET;
         cfg_ff.hot_x  <= '0;
         cfg_ff.hot_y  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/pointer_motion_accelerator.sv -----
// Top level: report sequencer, position state and result register.
//
// One report or recenter beat is accepted while the sequencer is idle and
// then runs through 14 sequencer steps to a valid result. Twelve of those
// steps are passes through a single shared multiply-add unit (gain scaling,
// the divide by 100 done as a reciprocal multiply, magnitude scaling and the
// hotspot scaling for both axes); one more captures the last quotient and the
// final step updates the position. req_ready is high only while the sequencer
// is idle and out of reset, so a new beat is taken only once the last one has
// left the update step. The result sits in an output register; if it has not
// been taken by the time the next one is done, the sequencer holds in its last
// step until rsp_ready frees it.
module pointer_motion_accelerator #(
   parameter int COORD_BITS = 13
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input beats
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_opcode,
   input  logic signed [pma_pkg::RAW_W-1:0]        req_dx_raw,
   input  logic signed [pma_pkg::RAW_W-1:0]        req_dy_raw,
   input  logic signed [pma_pkg::RAW_W-1:0]        req_wheel_raw,
   input  logic [pma_pkg::BTN_W-1:0]               req_buttons_raw,
   // result beats
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [pma_pkg::POS_OUT_W-1:0]           rsp_pos_x,
   output logic [pma_pkg::POS_OUT_W-1:0]           rsp_pos_y,
   output logic signed [pma_pkg::DRAW_W-1:0]       rsp_draw_x,
   output logic signed [pma_pkg::DRAW_W-1:0]       rsp_draw_y,
   output logic signed [pma_pkg::MOVE_W-1:0]       rsp_move_x,
   output logic signed [pma_pkg::MOVE_W-1:0]       rsp_move_y,
   output logic signed [pma_pkg::RAW_W-1:0]        rsp_wheel,
   output logic [pma_pkg::BTN_W-1:0]               rsp_buttons,
   // configuration writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pma_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [pma_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int LIM_W   = (COORD_BITS > pma_pkg::DIM_W) ? COORD_BITS : pma_pkg::DIM_W;
   localparam int SUM_W   = ((COORD_BITS > pma_pkg::MOVE_W) ? COORD_BITS
                                                            : pma_pkg::MOVE_W) + 2;
   localparam int POS_X_W = (COORD_BITS > pma_pkg::POS_OUT_W) ? COORD_BITS
                                                              : pma_pkg::POS_OUT_W;
   localparam int DIFF_W  = POS_X_W + 1;
   localparam logic [LIM_W-1:0] COORD_MAX = LIM_W'({COORD_BITS{1'b1}});

   pma_pkg::cfg_type            cfg;
   pma_pkg::mac_op_type         mac_op;
   logic [pma_pkg::PROD_W-1:0]  prod;

   pma_pkg::state_type          state_ff;
   pma_pkg::state_type          state_in;

   // latched beat
   logic                                 recenter_ff;
   logic [pma_pkg::MAG_W-1:0]            mag_x_ff;
   logic [pma_pkg::MAG_W-1:0]            mag_y_ff;
   logic                                 neg_x_ff;
   logic                                 neg_y_ff;
   logic signed [pma_pkg::RAW_W-1:0]     wheel_ff;
   logic [pma_pkg::BTN_W-1:0]            buttons_ff;

   // intermediate results
   logic signed [pma_pkg::MOVE_W-1:0]    move_x_ff;
   logic signed [pma_pkg::MOVE_W-1:0]    move_y_ff;
   logic [pma_pkg::HOT_SCALED_W-1:0]     hot_x_ff;
   logic [pma_pkg::HOT_SCALED_W-1:0]     hot_y_ff;

   // position state
   logic [COORD_BITS-1:0]                pos_x_ff;
   logic [COORD_BITS-1:0]                pos_y_ff;
   logic [COORD_BITS-1:0]                pos_x_in;
   logic [COORD_BITS-1:0]                pos_y_in;

   // result register
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [pma_pkg::POS_OUT_W-1:0]        rsp_pos_x_ff;
   logic [pma_pkg::POS_OUT_W-1:0]        rsp_pos_y_ff;
   logic signed [pma_pkg::DRAW_W-1:0]    rsp_draw_x_ff;
   logic signed [pma_pkg::DRAW_W-1:0]    rsp_draw_y_ff;
   logic signed [pma_pkg::MOVE_W-1:0]    rsp_move_x_ff;
   logic signed [pma_pkg::MOVE_W-1:0]    rsp_move_y_ff;
   logic signed [pma_pkg::RAW_W-1:0]     rsp_wheel_ff;
   logic [pma_pkg::BTN_W-1:0]            rsp_buttons_ff;

   logic                                 req_take;
   logic                                 out_free;
   logic                                 commit;
   logic signed [pma_pkg::MAG_W-1:0]     dx_ext;
   logic signed [pma_pkg::MAG_W-1:0]     dy_ext;
   logic [POS_X_W-1:0]                   pos_x_ext;
   logic [POS_X_W-1:0]                   pos_y_ext;
   logic [DIFF_W-1:0]                    diff_x;
   logic [DIFF_W-1:0]                    diff_y;

   // Gain step from the delta's magnitude
   function automatic logic [pma_pkg::GAIN_W-1:0] gain_for(
      input logic [pma_pkg::MAG_W-1:0] mag
   );
      logic [pma_pkg::GAIN_W-1:0] g;
      if (mag >= pma_pkg::THR_HIGH) begin
         g = pma_pkg::GAIN_HIGH;
      end else if (mag >= pma_pkg::THR_MID) begin
         g = pma_pkg::GAIN_MID;
      end else if (mag >= pma_pkg::THR_LOW) begin
         g = pma_pkg::GAIN_LOW;
      end else begin
         g = pma_pkg::GAIN_UNITY;
      end
      return g;
   endfunction

   // Signed move from rounded magnitude; nonzero input moves at least one
   function automatic logic signed [pma_pkg::MOVE_W-1:0] move_for(
      input logic [pma_pkg::MOVE_MAG_W-1:0] q,
      input logic [pma_pkg::MAG_W-1:0]      mag,
      input logic                           neg
   );
      logic [pma_pkg::MOVE_MAG_W-1:0] s;
      logic [pma_pkg::MOVE_W-1:0]     m;
      s = q;
      if (s == '0) begin
         s = pma_pkg::MOVE_MAG_W'(1);
      end
      m = pma_pkg::MOVE_W'(s);
      if (mag == '0) begin
         m = '0;
      end else if (neg) begin
         m = -m;
      end
      return $signed(m);
   endfunction

   // Next position on one axis, or half the size on a recenter, clamped to the screen
   function automatic logic [COORD_BITS-1:0] axis_next(
      input logic                              recenter,
      input logic [COORD_BITS-1:0]             pos,
      input logic signed [pma_pkg::MOVE_W-1:0] mv,
      input logic [pma_pkg::DIM_W-1:0]         dim
   );
      logic [LIM_W-1:0]        m;
      logic [LIM_W-1:0]        hi;
      logic signed [SUM_W-1:0] hi_s;
      logic signed [SUM_W-1:0] sum;
      logic [COORD_BITS-1:0]   r;
      m    = (dim != '0) ? (LIM_W'(dim) - LIM_W'(1)) : '0;
      hi   = (m > COORD_MAX) ? COORD_MAX : m;
      hi_s = $signed(SUM_W'(hi));
      if (recenter) begin
         sum = $signed(SUM_W'(dim >> 1));
      end else begin
         sum = $signed(SUM_W'(pos)) + SUM_W'(mv);
      end
      if (sum < 0) begin
         r = '0;
      end else if (sum > hi_s) begin
         r = COORD_BITS'(hi);
      end else begin
         r = COORD_BITS'(sum);
      end
      return r;
   endfunction

   pma_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pma_mac u_mac (
      .clock (clock),
      .op    (mac_op),
      .prod  (prod)
   );

   assign req_ready = (state_ff == pma_pkg::ST_IDLE) && !reset;
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == pma_pkg::ST_UPDATE) && out_free;

   // Sequencer: next step and operands of the shared unit
   always_comb begin
      state_in = state_ff;
      mac_op   = '0;
      unique case (state_ff)
         pma_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = pma_pkg::ST_X_GAIN;
            end
         end
         pma_pkg::ST_X_GAIN: begin
            mac_op.a = pma_pkg::MUL_W'(cfg.sens);
            mac_op.b = pma_pkg::MUL_W'(gain_for(mag_x_ff));
            state_in = pma_pkg::ST_X_FDIV;
         end
         pma_pkg::ST_Y_GAIN: begin
            mac_op.a = pma_pkg::MUL_W'(cfg.sens);
            mac_op.b = pma_pkg::MUL_W'(gain_for(mag_y_ff));
            state_in = pma_pkg::ST_Y_FDIV;
         end
         pma_pkg::ST_X_FDIV, pma_pkg::ST_X_SDIV, pma_pkg::ST_Y_FDIV,
         pma_pkg::ST_Y_SDIV, pma_pkg::ST_HX_DIV, pma_pkg::ST_HY_DIV: begin
            // divide by 100 as a reciprocal multiply
            mac_op.a = prod[pma_pkg::MUL_W-1:0];
            mac_op.b = pma_pkg::RECIP_100;
            unique case (state_ff)
               pma_pkg::ST_X_FDIV: state_in = pma_pkg::ST_X_MAG;
               pma_pkg::ST_X_SDIV: state_in = pma_pkg::ST_Y_GAIN;
               pma_pkg::ST_Y_FDIV: state_in = pma_pkg::ST_Y_MAG;
               pma_pkg::ST_Y_SDIV: state_in = pma_pkg::ST_HX_MUL;
               pma_pkg::ST_HX_DIV: state_in = pma_pkg::ST_HY_MUL;
               default:            state_in = pma_pkg::ST_HOT_CAP;
            endcase
         end
         pma_pkg::ST_X_MAG: begin
            mac_op.a = pma_pkg::MUL_W'(mag_x_ff);
            mac_op.b = pma_pkg::MUL_W'(prod[pma_pkg::RECIP_SHIFT +: pma_pkg::FACTOR_W]);
            mac_op.c = pma_pkg::ROUND_BIAS;
            state_in = pma_pkg::ST_X_SDIV;
         end
         pma_pkg::ST_Y_MAG: begin
            mac_op.a = pma_pkg::MUL_W'(mag_y_ff);
            mac_op.b = pma_pkg::MUL_W'(prod[pma_pkg::RECIP_SHIFT +: pma_pkg::FACTOR_W]);
            mac_op.c = pma_pkg::ROUND_BIAS;
            state_in = pma_pkg::ST_Y_SDIV;
         end
         pma_pkg::ST_HX_MUL: begin
            mac_op.a = pma_pkg::MUL_W'(cfg.hot_x);
            mac_op.b = pma_pkg::MUL_W'(pma_pkg::HOT_SCALE);
            mac_op.c = pma_pkg::ROUND_BIAS;
            state_in = pma_pkg::ST_HX_DIV;
         end
         pma_pkg::ST_HY_MUL: begin
            mac_op.a = pma_pkg::MUL_W'(cfg.hot_y);
            mac_op.b = pma_pkg::MUL_W'(pma_pkg::HOT_SCALE);
            mac_op.c = pma_pkg::ROUND_BIAS;
            state_in = pma_pkg::ST_HY_DIV;
         end
         pma_pkg::ST_HOT_CAP: begin
            state_in = pma_pkg::ST_UPDATE;
         end
         pma_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = pma_pkg::ST_IDLE;
            end
         end
         default: state_in = pma_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pma_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Beat latch: opcode, magnitudes and signs of the deltas, wheel and buttons
   assign dx_ext = pma_pkg::MAG_W'(req_dx_raw);
   assign dy_ext = pma_pkg::MAG_W'(req_dy_raw);

   always_ff @(posedge clock) begin
      if (req_take) begin
         recenter_ff <= req_opcode;
         mag_x_ff    <= dx_ext[pma_pkg::MAG_W-1] ? pma_pkg::MAG_W'(-dx_ext)
                                                 : pma_pkg::MAG_W'(dx_ext);
         mag_y_ff    <= dy_ext[pma_pkg::MAG_W-1] ? pma_pkg::MAG_W'(-dy_ext)
                                                 : pma_pkg::MAG_W'(dy_ext);
         neg_x_ff    <= dx_ext[pma_pkg::MAG_W-1];
         neg_y_ff    <= dy_ext[pma_pkg::MAG_W-1];
         wheel_ff    <= req_wheel_raw;
         buttons_ff  <= req_buttons_raw;
      end
   end

   // Quotients are taken from the shared unit in the step after their divide
   always_ff @(posedge clock) begin
      if (state_ff == pma_pkg::ST_Y_GAIN) begin
         move_x_ff <= move_for(prod[pma_pkg::RECIP_SHIFT +: pma_pkg::MOVE_MAG_W],
                               mag_x_ff, neg_x_ff);
      end
      if (state_ff == pma_pkg::ST_HX_MUL) begin
         move_y_ff <= move_for(prod[pma_pkg::RECIP_SHIFT +: pma_pkg::MOVE_MAG_W],
                               mag_y_ff, neg_y_ff);
      end
      if (state_ff == pma_pkg::ST_HY_MUL) begin
         hot_x_ff <= prod[pma_pkg::RECIP_SHIFT +: pma_pkg::HOT_SCALED_W];
      end
      if (state_ff == pma_pkg::ST_HOT_CAP) begin
         hot_y_ff <= prod[pma_pkg::RECIP_SHIFT +: pma_pkg::HOT_SCALED_W];
      end
   end

   // Position update and clamp
   assign pos_x_in = axis_next(recenter_ff, pos_x_ff, move_x_ff, cfg.width);
   assign pos_y_in = axis_next(recenter_ff, pos_y_ff, move_y_ff, cfg.height);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else if (commit) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // Draw position: position less scaled hotspot
   assign pos_x_ext = POS_X_W'(pos_x_in);
   assign pos_y_ext = POS_X_W'(pos_y_in);
   assign diff_x    = DIFF_W'(pos_x_in) - DIFF_W'(hot_x_ff);
   assign diff_y    = DIFF_W'(pos_y_in) - DIFF_W'(hot_y_ff);

   // Result register
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_pos_x_ff  <= pos_x_ext[pma_pkg::POS_OUT_W-1:0];
         rsp_pos_y_ff  <= pos_y_ext[pma_pkg::POS_OUT_W-1:0];
         rsp_draw_x_ff <= $signed(diff_x[pma_pkg::DRAW_W-1:0]);
         rsp_draw_y_ff <= $signed(diff_y[pma_pkg::DRAW_W-1:0]);
         if (recenter_ff) begin
            rsp_move_x_ff  <= '0;
            rsp_move_y_ff  <= '0;
            rsp_wheel_ff   <= '0;
            rsp_buttons_ff <= '0;
         end else begin
            rsp_move_x_ff  <= move_x_ff;
            rsp_move_y_ff  <= move_y_ff;
            rsp_wheel_ff   <= wheel_ff;
            rsp_buttons_ff <= buttons_ff;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_draw_x  = rsp_draw_x_ff;
   assign rsp_draw_y  = rsp_draw_y_ff;
   assign rsp_move_x  = rsp_move_x_ff;
   assign rsp_move_y  = rsp_move_y_ff;
   assign rsp_wheel   = rsp_wheel_ff;
   assign rsp_buttons = rsp_buttons_ff;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the pointer motion accelerator.
module tb;

   localparam logic OP_MOTION   = 1'b0;
   localparam logic OP_RECENTER = 1'b1;

   // indexes past the register list, writes there must be dropped
   localparam logic [pma_pkg::CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [pma_pkg::CSR_IDX_W-1:0] CSR_SPARE_MID   = 3'd6;
   localparam logic [pma_pkg::CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam int COORD_MAX   = 8191;
   localparam int CYCLE_LIMIT = 300000;
   localparam int TAIL_CYCLES = 40;

   typedef struct {
      logic [pma_pkg::POS_OUT_W-1:0]     pos_x;
      logic [pma_pkg::POS_OUT_W-1:0]     pos_y;
      logic signed [pma_pkg::DRAW_W-1:0] draw_x;
      logic signed [pma_pkg::DRAW_W-1:0] draw_y;
      logic signed [pma_pkg::MOVE_W-1:0] move_x;
      logic signed [pma_pkg::MOVE_W-1:0] move_y;
      logic signed [pma_pkg::RAW_W-1:0]  wheel;
      logic [pma_pkg::BTN_W-1:0]         buttons;
   } pointer_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid       = 1'b0;
   logic                               req_ready;
   logic                               req_opcode      = 1'b0;
   logic signed [pma_pkg::RAW_W-1:0]   req_dx_raw      = '0;
   logic signed [pma_pkg::RAW_W-1:0]   req_dy_raw      = '0;
   logic signed [pma_pkg::RAW_W-1:0]   req_wheel_raw   = '0;
   logic [pma_pkg::BTN_W-1:0]          req_buttons_raw = '0;

   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [pma_pkg::POS_OUT_W-1:0]      rsp_pos_x;
   logic [pma_pkg::POS_OUT_W-1:0]      rsp_pos_y;
   logic signed [pma_pkg::DRAW_W-1:0]  rsp_draw_x;
   logic signed [pma_pkg::DRAW_W-1:0]  rsp_draw_y;
   logic signed [pma_pkg::MOVE_W-1:0]  rsp_move_x;
   logic signed [pma_pkg::MOVE_W-1:0]  rsp_move_y;
   logic signed [pma_pkg::RAW_W-1:0]   rsp_wheel;
   logic [pma_pkg::BTN_W-1:0]          rsp_buttons;

   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [pma_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [pma_pkg::CSR_DATA_W-1:0]     csr_wdata = '0;

   // predictor copy of registers and position
   int sens_pct  = 100;
   int width_px  = 1920;
   int height_px = 1080;
   int hot_col   = 0;
   int hot_row   = 0;
   int ptr_x     = 0;
   int ptr_y     = 0;

   pointer_state_type due_states[$];
   int                mismatches    = 0;
   int                send_idle_pct = 23;
   int                recv_idle_pct = 49;
   int unsigned       cycle_count   = 0;

   pointer_motion_accelerator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_dx_raw      (req_dx_raw),
      .req_dy_raw      (req_dy_raw),
      .req_wheel_raw   (req_wheel_raw),
      .req_buttons_raw (req_buttons_raw),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_draw_x      (rsp_draw_x),
      .rsp_draw_y      (rsp_draw_y),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_wheel       (rsp_wheel),
      .rsp_buttons     (rsp_buttons),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL pointer_motion_accelerator");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   // gain banding by magnitude, round half up, never below one pixel for a nonzero delta
   function automatic int accel_delta(int raw);
      int mag;
      int gain;
      int s;
      if (raw == 0)
         return 0;
      mag  = (raw < 0) ? -raw : raw;
      gain = sens_pct;
      if (mag >= 24)
         gain = gain * 220 / 100;
      else if (mag >= 12)
         gain = gain * 170 / 100;
      else if (mag >= 6)
         gain = gain * 130 / 100;
      s = (mag * gain + 50) / 100;
      if (s == 0)
         s = 1;
      return (raw < 0) ? -s : s;
   endfunction

   function automatic int scaled_hotspot(int v);
      int s;
      s = (v * 150 + 50) / 100;
      if (v != 0 && s == 0)
         s = 1;
      return s;
   endfunction

   // zero size pins the axis to 0; oversize saturates at the coordinate range
   function automatic int clamp_axis(int v, int dim);
      int hi;
      hi = (dim != 0) ? dim - 1 : 0;
      if (hi > COORD_MAX)
         hi = COORD_MAX;
      if (v < 0)
         return 0;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic pointer_state_type next_pointer_state(
      input logic                             op,
      input logic signed [pma_pkg::RAW_W-1:0] dx,
      input logic signed [pma_pkg::RAW_W-1:0] dy,
      input logic signed [pma_pkg::RAW_W-1:0] wh,
      input logic [pma_pkg::BTN_W-1:0]        bt
   );
      pointer_state_type s;
      int mx;
      int my;
      mx        = 0;
      my        = 0;
      s.wheel   = '0;
      s.buttons = '0;
      if (op == OP_RECENTER) begin
         ptr_x = width_px / 2;
         ptr_y = height_px / 2;
      end else begin
         mx        = accel_delta(int'(dx));
         my        = accel_delta(int'(dy));
         s.wheel   = wh;
         s.buttons = bt;
         ptr_x     = ptr_x + mx;
         ptr_y     = ptr_y + my;
      end
      ptr_x    = clamp_axis(ptr_x, width_px);
      ptr_y    = clamp_axis(ptr_y, height_px);
      s.pos_x  = pma_pkg::POS_OUT_W'(ptr_x);
      s.pos_y  = pma_pkg::POS_OUT_W'(ptr_y);
      s.draw_x = pma_pkg::DRAW_W'(ptr_x - scaled_hotspot(hot_col));
      s.draw_y = pma_pkg::DRAW_W'(ptr_y - scaled_hotspot(hot_row));
      s.move_x = pma_pkg::MOVE_W'(mx);
      s.move_y = pma_pkg::MOVE_W'(my);
      return s;
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // compare each result beat with the oldest expectation; random back-pressure
   always @(posedge clock) begin
      pointer_state_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_states.size() == 0) begin
            $error("result beat with no expectation waiting");
            mismatches++;
         end else begin
            want = due_states.pop_front();
            check_field("pos_x",   int'(want.pos_x),   int'(rsp_pos_x));
            check_field("pos_y",   int'(want.pos_y),   int'(rsp_pos_y));
            check_field("draw_x",  int'(want.draw_x),  int'(rsp_draw_x));
            check_field("draw_y",  int'(want.draw_y),  int'(rsp_draw_y));
            check_field("move_x",  int'(want.move_x),  int'(rsp_move_x));
            check_field("move_y",  int'(want.move_y),  int'(rsp_move_y));
            check_field("wheel",   int'(want.wheel),   int'(rsp_wheel));
            check_field("buttons", int'(want.buttons), int'(rsp_buttons));
         end
      end
      rsp_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------- drivers

   // valid is left high after acceptance so back-to-back beats never toggle it
   task automatic send_report(
      input logic                             op,
      input logic signed [pma_pkg::RAW_W-1:0] dx,
      input logic signed [pma_pkg::RAW_W-1:0] dy,
      input logic signed [pma_pkg::RAW_W-1:0] wh,
      input logic [pma_pkg::BTN_W-1:0]        bt
   );
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_dx_raw      <= dx;
      req_dy_raw      <= dy;
      req_wheel_raw   <= wh;
      req_buttons_raw <= bt;
      do @(posedge clock); while (!req_ready);
      due_states.push_back(next_pointer_state(op, dx, dy, wh, bt));
   endtask

   // every item yields a result, so an empty queue means the block is idle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_states.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [pma_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pma_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pma_pkg::CSR_SENS: begin
            sens_pct = int'(data[pma_pkg::SENS_W-1:0]);
            if (sens_pct < 10)
               sens_pct = 10;
            if (sens_pct > 400)
               sens_pct = 400;
         end
         pma_pkg::CSR_WIDTH:  width_px  = int'(data);
         pma_pkg::CSR_HEIGHT: height_px = int'(data);
         pma_pkg::CSR_HOT_X:  hot_col   = int'(data[pma_pkg::HOT_W-1:0]);
         pma_pkg::CSR_HOT_Y:  hot_row   = int'(data[pma_pkg::HOT_W-1:0]);
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------- directed

   task automatic test_reset_state();
      send_report(OP_MOTION, 16'sd0, 16'sd0, 16'sh7FFF, 8'hFF);
      send_report(OP_RECENTER, 16'sd9, -16'sd9, 16'sd5, 8'h5A);
   endtask

   // each side of every gain threshold, both signs, full-scale counts
   task automatic test_accel_bands();
      send_report(OP_MOTION, 16'sd5, -16'sd5, -16'sd1, 8'h01);
      send_report(OP_MOTION, 16'sd6, -16'sd11, 16'sd1, 8'h80);
      send_report(OP_MOTION, 16'sd12, -16'sd23, 16'sd0, 8'h00);
      send_report(OP_MOTION, 16'sd24, -16'sh8000, 16'sh7FFF, 8'hFF);
      send_report(OP_MOTION, 16'sh7FFF, -16'sd1, -16'sh8000, 8'h00);
      send_report(OP_MOTION, -16'sh8000, 16'sh7FFF, 16'sd3, 8'hA5);
   endtask

   // writes below, above and at the lower limit; lowest gain still moves one pixel
   task automatic test_sensitivity();
      write_csr(pma_pkg::CSR_SENS, 14'd0);
      send_report(OP_MOTION, 16'sd1, -16'sd1, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_SENS, 14'd511);
      send_report(OP_MOTION, -16'sd4, -16'sd24, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_SENS, 14'h3FFF);
      send_report(OP_MOTION, 16'sd30, 16'sd7, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_SENS, 14'd10);
      send_report(OP_MOTION, -16'sd5, 16'sd25, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_SENS, 14'd100);
   endtask

   // zero size, oversize past the coordinate range, one-pixel axis
   task automatic test_screen_bounds();
      write_csr(pma_pkg::CSR_WIDTH, 14'd0);
      write_csr(pma_pkg::CSR_HEIGHT, 14'h3FFF);
      send_report(OP_RECENTER, 16'sd0, 16'sd0, 16'sd0, 8'h00);
      send_report(OP_MOTION, 16'sd5, 16'sh7FFF, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_WIDTH, 14'd8192);
      write_csr(pma_pkg::CSR_HEIGHT, 14'd1);
      send_report(OP_RECENTER, 16'sd0, 16'sd0, 16'sd0, 8'h00);
      send_report(OP_MOTION, 16'sh7FFF, 16'sd100, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_WIDTH, 14'd1920);
      write_csr(pma_pkg::CSR_HEIGHT, 14'd1080);
   endtask

   // largest and smallest nonzero hotspot, upper write bits ignored, draw below zero
   task automatic test_hotspot();
      write_csr(pma_pkg::CSR_HOT_X, 14'd255);
      write_csr(pma_pkg::CSR_HOT_Y, 14'd1);
      send_report(OP_RECENTER, 16'sd0, 16'sd0, 16'sd0, 8'h00);
      send_report(OP_MOTION, -16'sh8000, -16'sh8000, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_HOT_X, 14'h3F01);
      write_csr(pma_pkg::CSR_HOT_Y, 14'h3FFF);
      send_report(OP_MOTION, 16'sd0, 16'sd0, 16'sd0, 8'h00);
   endtask

   task automatic test_spare_index();
      write_csr(CSR_SPARE_FIRST, 14'h3FFF);
      write_csr(CSR_SPARE_MID, 14'd0);
      write_csr(CSR_SPARE_LAST, 14'h2AAA);
      send_report(OP_MOTION, 16'sd3, 16'sd3, 16'sd0, 8'h00);
      write_csr(pma_pkg::CSR_HOT_X, 14'd0);
      write_csr(pma_pkg::CSR_HOT_Y, 14'd0);
   endtask

   // ---------------------------------------------------------------- random

   // mostly small hand movements, some fast flicks, a few full-scale counts
   function automatic logic signed [pma_pkg::RAW_W-1:0] pick_delta();
      int v;
      case ($urandom_range(19))
         0, 1, 2:    v = $urandom();
         3, 4, 5, 6: v = int'($urandom_range(4000)) - 2000;
         default:    v = int'($urandom_range(80)) - 40;
      endcase
      return v[pma_pkg::RAW_W-1:0];
   endfunction

   function automatic logic [pma_pkg::CSR_DATA_W-1:0] pick_dimension();
      case ($urandom_range(9))
         0:       return '0;
         1:       return pma_pkg::CSR_DATA_W'($urandom_range(16383, 8192));
         2:       return pma_pkg::CSR_DATA_W'($urandom_range(16));
         default: return pma_pkg::CSR_DATA_W'($urandom_range(4000, 320));
      endcase
   endfunction

   task automatic randomise_settings();
      logic [pma_pkg::CSR_DATA_W-1:0] sens_word;
      case ($urandom_range(4))
         0:       sens_word = pma_pkg::CSR_DATA_W'($urandom_range(9));
         1:       sens_word = pma_pkg::CSR_DATA_W'($urandom_range(511, 400));
         2:       sens_word = pma_pkg::CSR_DATA_W'($urandom());
         default: sens_word = pma_pkg::CSR_DATA_W'($urandom_range(400, 10));
      endcase
      write_csr(pma_pkg::CSR_SENS, sens_word);
      write_csr(pma_pkg::CSR_WIDTH, pick_dimension());
      write_csr(pma_pkg::CSR_HEIGHT, pick_dimension());
      write_csr(pma_pkg::CSR_HOT_X, pma_pkg::CSR_DATA_W'($urandom()));
      write_csr(pma_pkg::CSR_HOT_Y, pma_pkg::CSR_DATA_W'($urandom()));
      if ($urandom_range(2) == 0)
         write_csr(pma_pkg::CSR_IDX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)),
                   pma_pkg::CSR_DATA_W'($urandom()));
   endtask

   task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                    input int beats);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int i = 0; i < beats; i++) begin
         if (i % 45 == 0)
            randomise_settings();
         send_report(($urandom_range(99) < 8) ? OP_RECENTER : OP_MOTION,
                     pick_delta(), pick_delta(),
                     pma_pkg::RAW_W'($urandom()), pma_pkg::BTN_W'($urandom()));
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_accel_bands();
      test_sensitivity();
      test_screen_bounds();
      test_hotspot();
      test_spare_index();
      test_random_phase(23, 49, 135);
      test_random_phase(49, 23, 135);
      test_random_phase(0, 0, 135);
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS pointer_motion_accelerator");
      else
         $display("FAIL pointer_motion_accelerator");
      $finish;
   end

endmodule
